@@ hdl/mftu_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor frame transform unit package
// Command codes, fixed coefficients and the elaboration-time helpers that
// build the sine table and the rounded transform constants.
// ----------------------------------------------------------------------------
package mftu_pkg;

	// Width of the intermediate sums: wide enough for a sum of two
	// products of a 32-bit operand and for an angle plus or minus one turn.
	localparam int WIDE_W = 34;

	// Quarter turn in radians, Q30.
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Clarke coefficients 2/3, 1/3 and 1/sqrt(3) in Q34.
	localparam longint unsigned K23_Q34  = 64'd11453246123;
	localparam longint unsigned K13_Q34  = 64'd5726623061;
	localparam longint unsigned KR3_Q34  = 64'd9918802098;

	// Operation selected by the command field.
	typedef enum logic [2:0] {
		CMD_CLARKE   = 3'd0,
		CMD_PARK     = 3'd1,
		CMD_INV_PARK = 3'd2,
		CMD_WRAP     = 3'd3,
		CMD_ERROR    = 3'd4
	} cmd_t;

	// Rounds a Q34 constant half up to the given number of fraction bits.
	function automatic logic [31:0] q34_round(input longint unsigned c, input int frac);
		longint unsigned r;
		r = (c + (64'd1 << (34 - frac - 1))) >> (34 - frac);
		return 32'(r);
	endfunction

	// One first-quadrant sine entry: a Taylor series to the seventeenth
	// power in Q30, clamped to [0, 1] and rounded half up to frac bits.
	function automatic logic [31:0] sine_entry(input int unsigned k, input int unsigned qbits,
		input int unsigned frac);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned mag;
		longint unsigned t;
		longint s;
		int n;
		x = ((64'(k) * HALF_PI_Q30) + ((64'd1 << qbits) >> 1)) >> qbits;
		x2 = (x * x) >> 30;
		mag = x;
		s = longint'(x);
		for (n = 1; n <= 8; n++) begin
			t = (mag * x2) >> 30;
			unique case (n)
				1: mag = t / 64'd6;
				2: mag = t / 64'd20;
				3: mag = t / 64'd42;
				4: mag = t / 64'd72;
				5: mag = t / 64'd110;
				6: mag = t / 64'd156;
				7: mag = t / 64'd210;
				8: mag = t / 64'd272;
				default: mag = t;
			endcase
			if (n[0]) begin
				s = s - longint'(mag);
			end else begin
				s = s + longint'(mag);
			end
		end
		if (s < 0) begin
			s = 0;
		end
		if (s > (64'sd1 <<< 30)) begin
			s = 64'sd1 <<< 30;
		end
		if (frac < 30) begin
			s = (s + (64'sd1 <<< (30 - frac - 1))) >>> (30 - frac);
		end
		return 32'(s);
	endfunction

endpackage

@@ hdl/motor_frame_transform_unit_top.sv @@
// ----------------------------------------------------------------------------
// Motor frame transform unit
// Clarke, Park and inverse Park transforms with angle wrap and angle error,
// in signed fixed point, on a four-stage pipeline of multipliers.
// ----------------------------------------------------------------------------
// A command is taken at every clock edge where start is high; busy is always
// low, so a new command may follow in every cycle. Each result appears on
// out_x, out_y and overflow with done high for one cycle, after its command
// has passed the four register stages, and results leave in the order the
// commands came in. The stages are the operand pre-sums, the sine table read
// with operand selection, the multipliers, and the final saturating sums. The
// receiver cannot hold results off, so nothing is queued inside the block.
module motor_frame_transform_unit_top #(
	parameter int DATA_WIDTH     = 32,
	parameter int FRAC_BITS      = 24,
	parameter int SINE_ADDR_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         command,
	input  logic signed [31:0] in_a,
	input  logic signed [31:0] in_b,
	input  logic signed [31:0] in_c,
	input  logic signed [31:0] rotor_angle,
	output logic               done,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic               overflow
);

	import mftu_pkg::*;

	// Coefficient width: holds sine values of plus and minus one.
	localparam int CW      = FRAC_BITS + 2;
	localparam int PW      = DATA_WIDTH + 1;
	localparam int QUARTER = 1 << (SINE_ADDR_BITS - 2);

	localparam logic signed [CW-1:0] K23 = signed'(CW'(q34_round(K23_Q34, FRAC_BITS)));
	localparam logic signed [CW-1:0] K13 = signed'(CW'(q34_round(K13_Q34, FRAC_BITS)));
	localparam logic signed [CW-1:0] KR3 = signed'(CW'(q34_round(KR3_Q34, FRAC_BITS)));

	localparam logic signed [WIDE_W-1:0] DMAX_W =
		signed'(WIDE_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1));
	localparam logic signed [WIDE_W-1:0] DMIN_W = -DMAX_W - 1;
	localparam logic signed [WIDE_W-1:0] HALF_W = signed'(WIDE_W'(64'd1 << (FRAC_BITS - 1)));
	localparam logic signed [WIDE_W-1:0] ONE_W  = signed'(WIDE_W'(64'd1 << FRAC_BITS));
	localparam logic [31:0] FRAC_MASK = (32'd1 << FRAC_BITS) - 32'd1;

	// True when a wide value lies outside the data range.
	function automatic logic out_of_range(input logic signed [WIDE_W-1:0] v);
		return (v > DMAX_W) || (v < DMIN_W);
	endfunction

	// Clamps a wide value to the data range.
	function automatic logic signed [DATA_WIDTH-1:0] clip(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] r;
		if (v > DMAX_W) begin
			r = DMAX_W;
		end else if (v < DMIN_W) begin
			r = DMIN_W;
		end else begin
			r = v;
		end
		return r[DATA_WIDTH-1:0];
	endfunction

	// Table address in the first quadrant, mirrored for odd quadrants.
	function automatic logic [SINE_ADDR_BITS-2:0] rom_addr(input logic [1:0] quad,
		input logic [SINE_ADDR_BITS-3:0] r);
		if (quad[0]) begin
			return (SINE_ADDR_BITS-1)'(QUARTER) - {1'b0, r};
		end
		return {1'b0, r};
	endfunction

	// ------------------------------------------------------------------
	// Quarter-wave sine table, a constant built at elaboration.
	// ------------------------------------------------------------------
	logic [FRAC_BITS:0] sine_rom [QUARTER+1];

	for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
		assign sine_rom[k] = (FRAC_BITS+1)'(sine_entry(k, SINE_ADDR_BITS - 2, FRAC_BITS));
	end

	// Every command is taken at once; the pipeline never stalls.
	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// Stage 1: operand pre-sums, angle wrap, raw angle error, table index.
	// ------------------------------------------------------------------
	cmd_t                      cmd_in;
	logic signed [DATA_WIDTH-1:0] a_op, b_op, c_op, ang_op;
	logic [31:0]               a_ext, ang_ext;
	logic signed [WIDE_W-1:0]  bpc_w, bmc_w, err_w, wrap_w;
	logic [SINE_ADDR_BITS-1:0] idx_in;
	logic signed [DATA_WIDTH-1:0] ang_n1;
	logic                      ovf_n1;

	assign cmd_in  = cmd_t'(command);
	assign a_op    = in_a[DATA_WIDTH-1:0];
	assign b_op    = in_b[DATA_WIDTH-1:0];
	assign c_op    = in_c[DATA_WIDTH-1:0];
	assign ang_op  = rotor_angle[DATA_WIDTH-1:0];
	assign a_ext   = 32'(a_op);
	assign ang_ext = 32'(ang_op);
	assign bpc_w   = WIDE_W'(b_op) + WIDE_W'(c_op);
	assign bmc_w   = WIDE_W'(b_op) - WIDE_W'(c_op);
	assign err_w   = WIDE_W'(a_op) - WIDE_W'(b_op);
	assign wrap_w  = signed'(WIDE_W'(a_ext & FRAC_MASK));

	// The table index is the top fraction bits of the angle, zero-padded below.
	if (FRAC_BITS >= SINE_ADDR_BITS) begin : g_idx_sel
		assign idx_in = ang_ext[FRAC_BITS-1 -: SINE_ADDR_BITS];
	end else begin : g_idx_pad
		assign idx_in = {ang_ext[FRAC_BITS-1:0], {(SINE_ADDR_BITS-FRAC_BITS){1'b0}}};
	end

	// Angle result and saturation so far, by command.
	always_comb begin
		ang_n1 = '0;
		ovf_n1 = 1'b0;
		unique case (cmd_in)
			CMD_CLARKE: begin
				ovf_n1 = out_of_range(bpc_w) | out_of_range(bmc_w);
			end
			CMD_PARK, CMD_INV_PARK: begin
				ovf_n1 = 1'b0;
			end
			CMD_WRAP: begin
				ang_n1 = clip(wrap_w);
				ovf_n1 = out_of_range(wrap_w);
			end
			CMD_ERROR: begin
				ang_n1 = clip(err_w);
				ovf_n1 = out_of_range(err_w);
			end
			default: begin
				ang_n1 = '0;
				ovf_n1 = 1'b0;
			end
		endcase
	end

	logic                         valid_s1;
	cmd_t                         cmd_s1;
	logic signed [DATA_WIDTH-1:0] op0_s1, op1_s1, op2_s1, ang_s1;
	logic                         ovf_s1;
	logic [SINE_ADDR_BITS-1:0]    idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd_in;
		op0_s1 <= a_op;
		op1_s1 <= (cmd_in == CMD_CLARKE) ? clip(bpc_w) : b_op;
		op2_s1 <= clip(bmc_w);
		ang_s1 <= ang_n1;
		ovf_s1 <= ovf_n1;
		idx_s1 <= idx_in;
	end

	// ------------------------------------------------------------------
	// Stage 2: sine and cosine lookup, multiplier operand selection and
	// the one-turn correction of the angle error.
	// ------------------------------------------------------------------
	logic [1:0]                sin_quad, cos_quad;
	logic [SINE_ADDR_BITS-3:0] quad_pos;
	logic [FRAC_BITS:0]        sin_mag, cos_mag;
	logic signed [CW-1:0]      sin_v, cos_v;

	assign sin_quad = idx_s1[SINE_ADDR_BITS-1 -: 2];
	assign cos_quad = sin_quad + 2'd1;
	assign quad_pos = idx_s1[SINE_ADDR_BITS-3:0];
	assign sin_mag  = sine_rom[rom_addr(sin_quad, quad_pos)];
	assign cos_mag  = sine_rom[rom_addr(cos_quad, quad_pos)];
	assign sin_v    = sin_quad[1] ? -signed'(CW'(sin_mag)) : signed'(CW'(sin_mag));
	assign cos_v    = cos_quad[1] ? -signed'(CW'(cos_mag)) : signed'(CW'(cos_mag));

	logic signed [DATA_WIDTH-1:0] m0a, m1a, m2a, m3a;
	logic signed [CW-1:0]         m0b, m1b, m2b, m3b;

	// Operand pairs for the four multipliers.
	always_comb begin
		m0a = '0; m0b = '0;
		m1a = '0; m1b = '0;
		m2a = '0; m2b = '0;
		m3a = '0; m3b = '0;
		unique case (cmd_s1)
			CMD_CLARKE: begin
				m0a = op0_s1; m0b = K23;
				m1a = op1_s1; m1b = K13;
				m2a = op2_s1; m2b = KR3;
			end
			CMD_PARK: begin
				m0a = op0_s1; m0b = cos_v;
				m1a = op1_s1; m1b = sin_v;
				m2a = op1_s1; m2b = cos_v;
				m3a = op0_s1; m3b = sin_v;
			end
			CMD_INV_PARK: begin
				m0a = op0_s1; m0b = cos_v;
				m1a = op1_s1; m1b = sin_v;
				m2a = op0_s1; m2b = sin_v;
				m3a = op1_s1; m3b = cos_v;
			end
			default: begin
				m0a = '0; m0b = '0;
			end
		endcase
	end

	logic signed [WIDE_W-1:0]     err_in, err_fix;
	logic signed [DATA_WIDTH-1:0] ang_n2;
	logic                         ovf_n2;

	// A single correction by one turn brings the error towards [-1/2, 1/2].
	assign err_in = WIDE_W'(ang_s1);

	always_comb begin
		priority if (err_in > HALF_W) begin
			err_fix = err_in - ONE_W;
		end else if (err_in < -HALF_W) begin
			err_fix = err_in + ONE_W;
		end else begin
			err_fix = err_in;
		end
	end

	always_comb begin
		if (cmd_s1 == CMD_ERROR) begin
			ang_n2 = clip(err_fix);
			ovf_n2 = ovf_s1 | out_of_range(err_fix);
		end else begin
			ang_n2 = ang_s1;
			ovf_n2 = ovf_s1;
		end
	end

	logic                         valid_s2;
	cmd_t                         cmd_s2;
	logic signed [DATA_WIDTH-1:0] m0a_s2, m1a_s2, m2a_s2, m3a_s2, ang_s2;
	logic signed [CW-1:0]         m0b_s2, m1b_s2, m2b_s2, m3b_s2;
	logic                         ovf_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2 <= cmd_s1;
		m0a_s2 <= m0a;
		m1a_s2 <= m1a;
		m2a_s2 <= m2a;
		m3a_s2 <= m3a;
		m0b_s2 <= m0b;
		m1b_s2 <= m1b;
		m2b_s2 <= m2b;
		m3b_s2 <= m3b;
		ang_s2 <= ang_n2;
		ovf_s2 <= ovf_n2;
	end

	// ------------------------------------------------------------------
	// Stage 3: four multipliers; the products are floored by taking the
	// bits above the fraction.
	// ------------------------------------------------------------------
	logic signed [DATA_WIDTH+CW-1:0] full0, full1, full2, full3;

	assign full0 = m0a_s2 * m0b_s2;
	assign full1 = m1a_s2 * m1b_s2;
	assign full2 = m2a_s2 * m2b_s2;
	assign full3 = m3a_s2 * m3b_s2;

	logic                         valid_s3;
	cmd_t                         cmd_s3;
	logic signed [PW-1:0]         p0_s3, p1_s3, p2_s3, p3_s3;
	logic signed [DATA_WIDTH-1:0] ang_s3;
	logic                         ovf_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s3 <= cmd_s2;
		p0_s3  <= full0[FRAC_BITS +: PW];
		p1_s3  <= full1[FRAC_BITS +: PW];
		p2_s3  <= full2[FRAC_BITS +: PW];
		p3_s3  <= full3[FRAC_BITS +: PW];
		ang_s3 <= ang_s2;
		ovf_s3 <= ovf_s2;
	end

	// ------------------------------------------------------------------
	// Stage 4: saturating sums and the output register.
	// ------------------------------------------------------------------
	logic signed [WIDE_W-1:0]     sum_x, sum_y;
	logic signed [DATA_WIDTH-1:0] x_n4, y_n4;
	logic                         ovf_n4;

	// Park adds in x and subtracts in y; Clarke and inverse Park the reverse.
	assign sum_x = (cmd_s3 == CMD_PARK) ? WIDE_W'(p0_s3) + WIDE_W'(p1_s3)
	                                    : WIDE_W'(p0_s3) - WIDE_W'(p1_s3);
	assign sum_y = (cmd_s3 == CMD_PARK) ? WIDE_W'(p2_s3) - WIDE_W'(p3_s3)
	                                    : WIDE_W'(p2_s3) + WIDE_W'(p3_s3);

	always_comb begin
		x_n4   = '0;
		y_n4   = '0;
		ovf_n4 = 1'b0;
		unique case (cmd_s3)
			CMD_CLARKE, CMD_PARK, CMD_INV_PARK: begin
				x_n4   = clip(sum_x);
				y_n4   = clip(sum_y);
				ovf_n4 = ovf_s3 | out_of_range(sum_x) | out_of_range(sum_y);
			end
			CMD_WRAP, CMD_ERROR: begin
				x_n4   = ang_s3;
				ovf_n4 = ovf_s3;
			end
			default: begin
				x_n4 = '0;
			end
		endcase
	end

	logic                         valid_s4;
	logic signed [DATA_WIDTH-1:0] x_s4, y_s4;
	logic                         ovf_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s4   <= x_n4;
		y_s4   <= y_n4;
		ovf_s4 <= ovf_n4;
	end

	// Each result transfer lasts exactly one cycle.
	assign done     = valid_s4;
	assign out_x    = 32'(x_s4);
	assign out_y    = 32'(y_s4);
	assign overflow = ovf_s4;

endmodule
